FILE: sv/dual_stream_audio_merge_fifo_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual stream audio merge FIFO
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DUAL_STREAM_AUDIO_MERGE_FIFO_DEFINES_SVH
`define DUAL_STREAM_AUDIO_MERGE_FIFO_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a condition in the same cycle as its trigger
`define DSAM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsam check failed");
// Check a condition in the cycle after its trigger
`define DSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsam check failed");
`else
`define DSAM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define DSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/dsam_pkg.sv
// ----------------------------------------------------------------------------
// dsam_pkg
// Types, codes and defaults shared by the audio merge FIFO modules.
// ----------------------------------------------------------------------------
package dsam_pkg;

   // default sizes
   localparam int FIFO_DEPTH_DEF     = 1024;
   localparam int MAX_CHANNELS_DEF   = 8;
   localparam int MAX_POP_FRAMES_DEF = 8;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int FRAMES_W = 4;
   localparam int CHAN_W   = 4;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // saturation limits
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // register reset values
   localparam logic              MIC_EN_RST   = 1'b1;
   localparam logic              SYS_EN_RST   = 1'b1;
   localparam logic [CHAN_W-1:0] CHAN_CNT_RST = 4'd2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIC_ENABLED,
      CSR_SYSTEM_ENABLED,
      CSR_CHANNEL_COUNT
   } csr_index_type;

   // input operations
   typedef enum logic [OP_W-1:0] {
      OP_APPEND_MIC,
      OP_APPEND_SYS,
      OP_POP
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_POP_SAMPLE,
      ST_APPENDED,
      ST_DROP_FULL,
      ST_DROP_DISABLED,
      ST_NOTHING_READY
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_READ,
      S_EMIT
   } state_type;

   // configuration handed from the register bank to the controller
   typedef struct packed {
      logic              mic_enabled;
      logic              system_enabled;
      logic [CHAN_W-1:0] channel_count;
   } cfg_type;

endpackage

FILE: sv/dsam_store.sv
// ----------------------------------------------------------------------------
// dsam_store
// One sample store: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module dsam_store #(
   parameter int DEPTH  = dsam_pkg::FIFO_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic signed [dsam_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic signed [dsam_pkg::SAMPLE_W-1:0] rd_data
);
   import dsam_pkg::*;

   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // write a word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read a word, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/dsam_ctrl.sv
// ----------------------------------------------------------------------------
// dsam_ctrl
// FIFO pointers, pop sequencer, sample merge and the result register.
// ----------------------------------------------------------------------------
module dsam_ctrl #(
   parameter int FIFO_DEPTH     = dsam_pkg::FIFO_DEPTH_DEF,
   parameter int MAX_CHANNELS   = dsam_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_POP_FRAMES = dsam_pkg::MAX_POP_FRAMES_DEF,
   parameter int AW             = $clog2(FIFO_DEPTH),
   parameter int FW             = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dsam_pkg::cfg_type                    cfg,
   // request words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dsam_pkg::OP_W-1:0]            req_operation,
   input  logic [dsam_pkg::FRAMES_W-1:0]        req_max_frames,
   // store ports
   output logic                                 mic_wr_en,
   output logic [AW-1:0]                        mic_wr_addr,
   output logic                                 mic_rd_en,
   output logic [AW-1:0]                        mic_rd_addr,
   input  logic signed [dsam_pkg::SAMPLE_W-1:0] mic_rd_data,
   output logic                                 sys_wr_en,
   output logic [AW-1:0]                        sys_wr_addr,
   output logic                                 sys_rd_en,
   output logic [AW-1:0]                        sys_rd_addr,
   input  logic signed [dsam_pkg::SAMPLE_W-1:0] sys_rd_data,
   // response words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dsam_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_last,
   output logic [dsam_pkg::FRAMES_W-1:0]        rsp_frames_popped,
   output logic [dsam_pkg::STATUS_W-1:0]        rsp_status
);
   import dsam_pkg::*;

   localparam int CNT_W = $clog2(MAX_POP_FRAMES * MAX_CHANNELS + 1);
   localparam int SW    = FW + 1;
   localparam int CMP_W = (FW > 8) ? FW : 8;
   localparam logic [SW-1:0]       DEPTH_S  = SW'(FIFO_DEPTH);
   localparam logic [FW-1:0]       DEPTH_F  = FW'(FIFO_DEPTH);
   localparam logic [AW-1:0]       LAST_POS = AW'(FIFO_DEPTH - 1);
   localparam logic [CHAN_W-1:0]   CH_MAX   = CHAN_W'(MAX_CHANNELS);
   localparam logic [FRAMES_W-1:0] FR_MAX   = FRAMES_W'(MAX_POP_FRAMES);

   state_type                 state_ff, state_in;
   logic [AW-1:0]             mic_head_ff, mic_head_in, sys_head_ff, sys_head_in;
   logic [FW-1:0]             mic_fill_ff, mic_fill_in, sys_fill_ff, sys_fill_in;
   logic [FRAMES_W-1:0]       maxf_ff, maxf_in, frames_ff, frames_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [FRAMES_W-1:0]       rsp_frames_ff, rsp_frames_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      out_free;
   logic                      accept;
   logic                      both_en;
   logic [CHAN_W-1:0]         ch_sat;
   logic [FW-1:0]             min_fill;
   logic [FRAMES_W-1:0]       frames_calc;
   logic [2*CHAN_W-1:0]       count_calc;
   logic signed [SAMPLE_W:0]  sum_wide;
   logic signed [SAMPLE_W-1:0] merged;

   // wrap head plus fill into a store address
   function automatic logic [AW-1:0] tail_pos(input logic [AW-1:0] head,
                                              input logic [FW-1:0] fill);
      logic [SW-1:0] pos;
      pos = SW'(head) + SW'(fill);
      if (pos >= DEPTH_S) begin
         pos = pos - DEPTH_S;
      end
      return pos[AW-1:0];
   endfunction

   // step a head pointer round the store
   function automatic logic [AW-1:0] head_step(input logic [AW-1:0] head);
      return (head == LAST_POS) ? '0 : head + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign both_en   = cfg.mic_enabled && cfg.system_enabled;

   // clamp the channel count
   always_comb begin
      priority if (cfg.channel_count == '0) begin
         ch_sat = CHAN_W'(1);
      end else if (cfg.channel_count > CH_MAX) begin
         ch_sat = CH_MAX;
      end else begin
         ch_sat = cfg.channel_count;
      end
   end

   // find the ready fill over the enabled streams
   always_comb begin
      priority if (both_en) begin
         min_fill = (mic_fill_ff < sys_fill_ff) ? mic_fill_ff : sys_fill_ff;
      end else if (cfg.mic_enabled) begin
         min_fill = mic_fill_ff;
      end else if (cfg.system_enabled) begin
         min_fill = sys_fill_ff;
      end else begin
         min_fill = '0;
      end
   end

   // take the largest frame count that fits both the fill and the limit
   always_comb begin
      frames_calc = '0;
      for (int f = 1; f <= MAX_POP_FRAMES; f++) begin
         if ((CMP_W'(f) * CMP_W'(ch_sat) <= CMP_W'(min_fill)) &&
             (FRAMES_W'(f) <= maxf_ff)) begin
            frames_calc = FRAMES_W'(f);
         end
      end
   end

   assign count_calc = (2*CHAN_W)'(frames_calc) * (2*CHAN_W)'(ch_sat);

   // merge the two read words with saturation when both streams are enabled, else pass one stream's word
   always_comb begin
      sum_wide = {mic_rd_data[SAMPLE_W-1], mic_rd_data} +
                 {sys_rd_data[SAMPLE_W-1], sys_rd_data};
      priority if (both_en) begin
         if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
            merged = sum_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
         end else begin
            merged = sum_wide[SAMPLE_W-1:0];
         end
      end else if (cfg.mic_enabled) begin
         merged = mic_rd_data;
      end else begin
         merged = sys_rd_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_operation == OP_POP)) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (frames_calc != '0) begin
               state_in = S_READ;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = (remain_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and store control
   always_comb begin
      mic_head_in   = mic_head_ff;
      sys_head_in   = sys_head_ff;
      mic_fill_in   = mic_fill_ff;
      sys_fill_in   = sys_fill_ff;
      maxf_in       = maxf_ff;
      frames_in     = frames_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_status_in = rsp_status_ff;
      mic_wr_en     = 1'b0;
      sys_wr_en     = 1'b0;
      mic_rd_en     = 1'b0;
      sys_rd_en     = 1'b0;
      mic_wr_addr   = tail_pos(mic_head_ff, mic_fill_ff);
      sys_wr_addr   = tail_pos(sys_head_ff, sys_fill_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_APPEND_MIC: begin
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_last_in   = 1'b1;
                     rsp_frames_in = '0;
                     priority if (!cfg.mic_enabled) begin
                        rsp_status_in = ST_DROP_DISABLED;
                     end else if (mic_fill_ff == DEPTH_F) begin
                        rsp_status_in = ST_DROP_FULL;
                     end else begin
                        mic_wr_en     = 1'b1;
                        mic_fill_in   = mic_fill_ff + 1'b1;
                        rsp_status_in = ST_APPENDED;
                     end
                  end
                  OP_APPEND_SYS: begin
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_last_in   = 1'b1;
                     rsp_frames_in = '0;
                     priority if (!cfg.system_enabled) begin
                        rsp_status_in = ST_DROP_DISABLED;
                     end else if (sys_fill_ff == DEPTH_F) begin
                        rsp_status_in = ST_DROP_FULL;
                     end else begin
                        sys_wr_en     = 1'b1;
                        sys_fill_in   = sys_fill_ff + 1'b1;
                        rsp_status_in = ST_APPENDED;
                     end
                  end
                  OP_POP: begin
                     maxf_in = (req_max_frames > FR_MAX) ? FR_MAX : req_max_frames;
                  end
                  default: begin
                     // unused code: drop the word silently
                  end
               endcase
            end
         end
         S_CALC: begin
            if (frames_calc != '0) begin
               frames_in = frames_calc;
               remain_in = count_calc[CNT_W-1:0];
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_last_in   = 1'b1;
               rsp_frames_in = '0;
               rsp_status_in = ST_NOTHING_READY;
            end
         end
         S_READ: begin
            remain_in = remain_ff - 1'b1;
            if (cfg.mic_enabled) begin
               mic_rd_en   = 1'b1;
               mic_head_in = head_step(mic_head_ff);
               mic_fill_in = mic_fill_ff - 1'b1;
            end
            if (cfg.system_enabled) begin
               sys_rd_en   = 1'b1;
               sys_head_in = head_step(sys_head_ff);
               sys_fill_in = sys_fill_ff - 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = merged;
               rsp_last_in   = (remain_ff == '0);
               rsp_frames_in = frames_ff;
               rsp_status_in = ST_POP_SAMPLE;
            end
         end
         default: begin
         end
      endcase
   end

   assign mic_rd_addr = mic_head_ff;
   assign sys_rd_addr = sys_head_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mic_head_ff  <= '0;
         sys_head_ff  <= '0;
         mic_fill_ff  <= '0;
         sys_fill_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mic_head_ff  <= mic_head_in;
         sys_head_ff  <= sys_head_in;
         mic_fill_ff  <= mic_fill_in;
         sys_fill_ff  <= sys_fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      maxf_ff       <= maxf_in;
      frames_ff     <= frames_in;
      remain_ff     <= remain_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_frames_popped = rsp_frames_ff;
   assign rsp_status        = STATUS_W'(rsp_status_ff);

endmodule

FILE: sv/dual_stream_audio_merge_fifo.sv
// ----------------------------------------------------------------------------
// dual_stream_audio_merge_fifo
// Microphone and system sample FIFOs merged into one output stream.
// ----------------------------------------------------------------------------
// Usage:
//   Request words carry an operation: append a microphone sample, append a
//   system sample, or pop up to req_max_frames frames. Each append answers
//   with one response word (kept, dropped full or dropped disabled) in the
//   cycle after acceptance; appends can be taken one per cycle while the
//   receiver takes every response word. A pop sizes the transfer in the
//   calc state, then passes every sample through a store read state and a
//   state loading the response register. It emits frames times channels
//   words, the last one flagged, or one "nothing ready" word. No request
//   is taken until a pop has finished. The sequencer alternates the read
//   and load states per sample; a stalled receiver holds the load state.
//   The CSR port (csr_write_enable, csr_index, csr_write_data) writes the
//   stream enables and the channel count; write it only while idle.
//   Reset clears the FIFO pointers and fills, sets both streams enabled and
//   two channels; the stores themselves are not cleared.
//   A stalled receiver holds the response word; the request side then waits.
// ----------------------------------------------------------------------------
`include "dual_stream_audio_merge_fifo_defines.svh"

module dual_stream_audio_merge_fifo #(
   parameter int FIFO_DEPTH     = dsam_pkg::FIFO_DEPTH_DEF,
   parameter int MAX_CHANNELS   = dsam_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_POP_FRAMES = dsam_pkg::MAX_POP_FRAMES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [dsam_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dsam_pkg::CSR_DATA_W-1:0]      csr_write_data,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dsam_pkg::OP_W-1:0]            req_operation,
   input  logic signed [dsam_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [dsam_pkg::FRAMES_W-1:0]        req_max_frames,
   // responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dsam_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_last,
   output logic [dsam_pkg::FRAMES_W-1:0]        rsp_frames_popped,
   output logic [dsam_pkg::STATUS_W-1:0]        rsp_status
);
   import dsam_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);

   cfg_type                    cfg_ff, cfg_in;
   logic                       mic_wr_en, sys_wr_en, mic_rd_en, sys_rd_en;
   logic [AW-1:0]              mic_wr_addr, sys_wr_addr, mic_rd_addr, sys_rd_addr;
   logic signed [SAMPLE_W-1:0] mic_rd_data, sys_rd_data;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIC_ENABLED:    cfg_in.mic_enabled    = csr_write_data[0];
            CSR_SYSTEM_ENABLED: cfg_in.system_enabled = csr_write_data[0];
            CSR_CHANNEL_COUNT:  cfg_in.channel_count  = csr_write_data[CHAN_W-1:0];
            default: begin
               // unmapped index: ignore the word
            end
         endcase
      end
   end

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mic_enabled    <= MIC_EN_RST;
         cfg_ff.system_enabled <= SYS_EN_RST;
         cfg_ff.channel_count  <= CHAN_CNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsam_store #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (AW)
   ) u_mic_store (
      .clock   (clock),
      .wr_en   (mic_wr_en),
      .wr_addr (mic_wr_addr),
      .wr_data (req_sample_in),
      .rd_en   (mic_rd_en),
      .rd_addr (mic_rd_addr),
      .rd_data (mic_rd_data)
   );

   dsam_store #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (AW)
   ) u_sys_store (
      .clock   (clock),
      .wr_en   (sys_wr_en),
      .wr_addr (sys_wr_addr),
      .wr_data (req_sample_in),
      .rd_en   (sys_rd_en),
      .rd_addr (sys_rd_addr),
      .rd_data (sys_rd_data)
   );

   dsam_ctrl #(
      .FIFO_DEPTH     (FIFO_DEPTH),
      .MAX_CHANNELS   (MAX_CHANNELS),
      .MAX_POP_FRAMES (MAX_POP_FRAMES),
      .AW             (AW),
      .FW             (FW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_max_frames    (req_max_frames),
      .mic_wr_en         (mic_wr_en),
      .mic_wr_addr       (mic_wr_addr),
      .mic_rd_en         (mic_rd_en),
      .mic_rd_addr       (mic_rd_addr),
      .mic_rd_data       (mic_rd_data),
      .sys_wr_en         (sys_wr_en),
      .sys_wr_addr       (sys_wr_addr),
      .sys_rd_en         (sys_rd_en),
      .sys_rd_addr       (sys_rd_addr),
      .sys_rd_data       (sys_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_last          (rsp_last),
      .rsp_frames_popped (rsp_frames_popped),
      .rsp_status        (rsp_status)
   );

   // a request is only taken when the response register can take its word
   `DSAM_ASSERT_NOW(a_ready_room, clock, reset, req_ready, (!rsp_valid || rsp_ready))
   // an accepted append answers next cycle with a single final word
   `DSAM_ASSERT_NEXT(a_append_rsp, clock, reset, (req_valid && req_ready && (req_operation == OP_APPEND_MIC || req_operation == OP_APPEND_SYS)), (rsp_valid && rsp_last && rsp_frames_popped == '0))
   // popped samples always report a non-zero frame count
   `DSAM_ASSERT_NOW(a_pop_frames, clock, reset, (rsp_valid && rsp_status == STATUS_W'(ST_POP_SAMPLE)), (rsp_frames_popped != '0))
   // an empty pop gives a zero final word
   `DSAM_ASSERT_NOW(a_empty_pop, clock, reset, (rsp_valid && rsp_status == STATUS_W'(ST_NOTHING_READY)), (rsp_last && rsp_sample_out == '0))

endmodule

FILE: tb/sv/dual_stream_audio_merge_fifo_tb.sv
// ----------------------------------------------------------------------------
// dual_stream_audio_merge_fifo_tb
// Self-checking bench for the dual stream audio merge FIFO. A behavioural
// copy of both sample FIFOs predicts every response word for each accepted
// request word. Directed tests cover saturation, channel limits and disabled
// streams. Randomised traffic then runs over several register settings
// while the sender pauses in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module dual_stream_audio_merge_fifo_tb;
   import dsam_pkg::*;

   localparam int DEPTH           = FIFO_DEPTH_DEF;
   localparam int MIC             = 0;
   localparam int SYS             = 1;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int CSR_SETTLE      = 8;
   localparam int TAIL_CYCLES     = 2 * MAX_CHANNELS_DEF * MAX_POP_FRAMES_DEF + 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_WORDS     = 20;

   // codes outside the decoded set
   localparam logic [OP_W-1:0]      OP_UNUSED        = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic [FRAMES_W-1:0]        frames;
      status_type                 status;
   } merged_word_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_MOSTLY_READY,
      RX_MOSTLY_HELD
   } rx_mode_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index        = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [OP_W-1:0]            req_operation    = '0;
   logic signed [SAMPLE_W-1:0] req_sample_in    = '0;
   logic [FRAMES_W-1:0]        req_max_frames   = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_last;
   logic [FRAMES_W-1:0]        rsp_frames_popped;
   logic [STATUS_W-1:0]        rsp_status;

   // behavioural copy of the two FIFOs and the registers
   logic [SAMPLE_W-1:0] stream_mem [2][DEPTH];
   int                  stream_head [2] = '{0, 0};
   int                  stream_fill [2] = '{0, 0};
   logic                stream_on [2]   = '{MIC_EN_RST, SYS_EN_RST};
   logic [CHAN_W-1:0]   chan_setting    = CHAN_CNT_RST;

   merged_word_type pending_words [$];
   int           mismatch_count = 0;
   int           words_sent     = 0;
   int           burst_left     = 0;
   int           cycle_count;
   logic         paced          = 1'b0;
   logic         hold_off_req   = 1'b0;
   int           hold_left      = 0;
   int           mode_left      = 0;
   rx_mode_type  rx_mode        = RX_STEADY;

   dual_stream_audio_merge_fifo DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_sample_in     (req_sample_in),
      .req_max_frames    (req_max_frames),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_last          (rsp_last),
      .rsp_frames_popped (rsp_frames_popped),
      .rsp_status        (rsp_status)
   );

   // free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   // abandon the run at a generous cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dual_stream_audio_merge_fifo test failed");
      $finish;
   end

   // channels per frame after clamping
   function automatic int frame_width();
      int ch;
      ch = (chan_setting == 0) ? 1 : int'(chan_setting);
      if (ch > MAX_CHANNELS_DEF) ch = MAX_CHANNELS_DEF;
      return ch;
   endfunction

   function automatic void push_word(input logic signed [SAMPLE_W-1:0] sample,
                                     input logic last, input logic [FRAMES_W-1:0] frames,
                                     input status_type status);
      merged_word_type w;
      w.sample = sample;
      w.last   = last;
      w.frames = frames;
      w.status = status;
      pending_words.push_back(w);
   endfunction

   // remove the oldest sample of one stream, sign extended
   function automatic int take_sample(input int s);
      int v;
      v = $signed(stream_mem[s][stream_head[s]]);
      stream_head[s] = (stream_head[s] + 1) % DEPTH;
      stream_fill[s]--;
      return v;
   endfunction

   // work out the response words of one accepted request word
   function automatic void predict_merge(input logic [OP_W-1:0] op,
                                         input logic signed [SAMPLE_W-1:0] sample,
                                         input logic [FRAMES_W-1:0] maxf);
      int s, ch, mf, ready, frames, count, i, v;
      ch = frame_width();
      case (op)
         OP_APPEND_MIC, OP_APPEND_SYS: begin
            s = (op == OP_APPEND_MIC) ? MIC : SYS;
            if (!stream_on[s]) begin
               push_word('0, 1'b1, '0, ST_DROP_DISABLED);
            end else if (stream_fill[s] >= DEPTH) begin
               push_word('0, 1'b1, '0, ST_DROP_FULL);
            end else begin
               stream_mem[s][(stream_head[s] + stream_fill[s]) % DEPTH] = sample;
               stream_fill[s]++;
               push_word('0, 1'b1, '0, ST_APPENDED);
            end
         end
         OP_POP: begin
            mf = (maxf > MAX_POP_FRAMES_DEF) ? MAX_POP_FRAMES_DEF : int'(maxf);
            if (stream_on[MIC] && stream_on[SYS]) begin
               ready = stream_fill[MIC] / ch;
               if (stream_fill[SYS] / ch < ready) ready = stream_fill[SYS] / ch;
            end else if (stream_on[MIC]) begin
               ready = stream_fill[MIC] / ch;
            end else if (stream_on[SYS]) begin
               ready = stream_fill[SYS] / ch;
            end else begin
               ready = 0;
            end
            frames = (mf < ready) ? mf : ready;
            if (frames == 0) begin
               push_word('0, 1'b1, '0, ST_NOTHING_READY);
            end else begin
               count = frames * ch;
               for (i = 0; i < count; i++) begin
                  if (stream_on[MIC] && stream_on[SYS]) begin
                     v = take_sample(MIC) + take_sample(SYS);
                     if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                     else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
                  end else if (stream_on[MIC]) begin
                     v = take_sample(MIC);
                  end else begin
                     v = take_sample(SYS);
                  end
                  push_word(SAMPLE_W'(v), i == count - 1, FRAMES_W'(frames), ST_POP_SAMPLE);
               end
            end
         end
         default: begin
            // unused operation: no state change and no word
         end
      endcase
   endfunction

   // sample values biased towards the saturation limits
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return SAMPLE_W'($urandom_range(0, 15));
         3:       return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // offer one request word and hold it until accepted
   task automatic send_word(input logic [OP_W-1:0] op,
                            input logic signed [SAMPLE_W-1:0] sample,
                            input logic [FRAMES_W-1:0] maxf);
      int gap;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_sample_in  <= sample;
      req_max_frames <= maxf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_merge(op, sample, maxf);
      if (op != OP_UNUSED) words_sent++;
      // close a burst with a random gap
      if (paced) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(0, 15);
         end
      end
   endtask

   // stop sending and wait for every expected word
   task automatic idle_until_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MIC_ENABLED:    stream_on[MIC] = data[0];
         CSR_SYSTEM_ENABLED: stream_on[SYS] = data[0];
         CSR_CHANNEL_COUNT:  chan_setting   = data;
         default: begin
         end
      endcase
   endtask

   // drain, then load all three registers; enable writes carry junk upper bits
   task automatic configure(input logic mic_en, input logic sys_en,
                            input logic [CHAN_W-1:0] chans);
      idle_until_drained();
      write_csr(CSR_MIC_ENABLED, {3'($urandom), mic_en});
      write_csr(CSR_SYSTEM_ENABLED, {3'($urandom), sys_en});
      write_csr(CSR_CHANNEL_COUNT, chans);
   endtask

   // reset settings: saturation both ways, frame limit, unused operation
   task automatic test_directed_basics();
      send_word(OP_APPEND_MIC, SAMPLE_MAX, 4'd0);
      send_word(OP_APPEND_SYS, 16'sd1, 4'd15);
      send_word(OP_APPEND_MIC, SAMPLE_MIN, 4'd0);
      send_word(OP_APPEND_SYS, -16'sd1, 4'd0);
      send_word(OP_POP, 16'sd0, 4'd0);
      send_word(OP_UNUSED, 16'shAAAA, 4'd15);
      send_word(OP_POP, 16'sh5555, 4'd15);
      send_word(OP_POP, 16'sd0, 4'd8);
      send_word(OP_APPEND_MIC, 16'sd12345, 4'd0);
      send_word(OP_APPEND_SYS, -16'sd12345, 4'd0);
      send_word(OP_APPEND_MIC, 16'sd100, 4'd0);
      send_word(OP_APPEND_SYS, 16'sd200, 4'd0);
      send_word(OP_POP, 16'sd0, 4'd1);
   endtask

   // zero channels behaves as one; unused register index is ignored
   task automatic test_channel_count_zero();
      configure(1'b1, 1'b1, 4'd0);
      write_csr(CSR_UNUSED_INDEX, 4'hF);
      send_word(OP_APPEND_MIC, -16'sd5, 4'd0);
      send_word(OP_APPEND_SYS, 16'sd3, 4'd0);
      send_word(OP_POP, 16'sd0, 4'd15);
   endtask

   // drops on disabled streams; held samples survive until re-enabled
   task automatic test_disabled_streams();
      configure(1'b1, 1'b0, 4'd1);
      send_word(OP_APPEND_SYS, 16'sd77, 4'd0);
      send_word(OP_APPEND_MIC, 16'sd9, 4'd0);
      send_word(OP_POP, 16'sd0, 4'd2);
      configure(1'b1, 1'b1, 4'd1);
      send_word(OP_APPEND_SYS, 16'sd40, 4'd0);
      configure(1'b1, 1'b0, 4'd1);
      send_word(OP_POP, 16'sd0, 4'd3);
      configure(1'b0, 1'b1, 4'd1);
      send_word(OP_POP, 16'sd0, 4'd3);
      configure(1'b0, 1'b0, 4'd1);
      send_word(OP_APPEND_MIC, 16'sd5, 4'd0);
      send_word(OP_POP, 16'sd0, 4'd8);
   endtask

   // long receiver hold-off while requests keep coming, then a full pause
   task automatic test_backpressure();
      int i;
      configure(1'b1, 1'b1, 4'd4);
      hold_off_req = 1'b1;
      for (i = 0; i < 24; i++)
         send_word(i[0] ? OP_APPEND_SYS : OP_APPEND_MIC, random_sample(), 4'd0);
      send_word(OP_POP, 16'sd0, 4'd15);
      idle_until_drained();
   endtask

   // mostly whole frame groups followed by a pop, some noise words
   task automatic test_random_traffic();
      int phase, budget_end, k, ch, i;
      paced = 1'b1;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: configure(1'b1, 1'b1, 4'd2);
            1: configure(1'b1, 1'b1, 4'd0);
            2: configure(1'b1, 1'b0, 4'd8);
            3: configure(1'b0, 1'b1, 4'd15);
            4: configure(1'b1, 1'b1, 4'($urandom_range(1, 15)));
            5: configure(1'b0, 1'b0, 4'($urandom_range(0, 15)));
            default: configure(1'b1, 1'b1, 4'd1);
         endcase
         budget_end = words_sent + PHASE_WORDS;
         while (words_sent < budget_end) begin
            if ($urandom_range(0, 9) < 7) begin
               ch = frame_width();
               k  = $urandom_range(1, 2);
               for (i = 0; i < k * ch; i++) begin
                  if (stream_on[MIC] || !stream_on[SYS])
                     send_word(OP_APPEND_MIC, random_sample(), 4'($urandom_range(0, 15)));
                  if (stream_on[SYS] || !stream_on[MIC])
                     send_word(OP_APPEND_SYS, random_sample(), 4'($urandom_range(0, 15)));
               end
               send_word(OP_POP, random_sample(), 4'($urandom_range(0, 15)));
            end else begin
               send_word(OP_W'($urandom_range(0, 3)), random_sample(),
                         4'($urandom_range(0, 15)));
            end
         end
      end
      paced = 1'b0;
   endtask

   // receiver: long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_STEADY:       rsp_ready <= 1'b1;
            RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY_READY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:         rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : check_words
      merged_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: sample_out %0d status %0d", rsp_sample_out, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_sample_out !== want.sample) begin
               $error("sample_out: expected %0d, got %0d", want.sample, rsp_sample_out);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_frames_popped !== want.frames) begin
               $error("frames_popped: expected %0d, got %0d", want.frames, rsp_frames_popped);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_channel_count_zero();
      test_disabled_streams();
      test_backpressure();
      test_random_traffic();
      idle_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         $error("%0d expected words never arrived", pending_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("dual_stream_audio_merge_fifo test passed");
      else
         $display("dual_stream_audio_merge_fifo test failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/dsam_pkg.sv
sv/dsam_store.sv
sv/dsam_ctrl.sv
sv/dual_stream_audio_merge_fifo.sv
tb/sv/dual_stream_audio_merge_fifo_tb.sv
